[rtl/core/robust_residual_weighting_unit_macros.svh]
// ----------------------------------------------------------------------------
// robust residual weighting: assertion macros
// shared concurrent assertion forms, clocked and reset-qualified
// ----------------------------------------------------------------------------
`ifndef ROBUST_RESIDUAL_WEIGHTING_UNIT_MACROS_SVH
`define ROBUST_RESIDUAL_WEIGHTING_UNIT_MACROS_SVH

// same-cycle implication
`define RRW_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("robust residual weighting check failed");

// next-cycle implication
`define RRW_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("robust residual weighting check failed");

`endif

[rtl/core/rrw_pkg.sv]
// ----------------------------------------------------------------------------
// rrw_pkg
// types and constants shared by the robust residual weighting unit
// ----------------------------------------------------------------------------
package rrw_pkg;

    // field widths
    localparam int RES_W    = 24;
    localparam int WEIGHT_W = 18;
    localparam int SCALE_W  = 24;
    localparam int PAR_W    = 16;
    localparam int XSQ_W    = 48;

    // fixed-point constants
    localparam logic [SCALE_W-1:0]  SCALE_MIN  = 24'd66;
    localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = 18'd65536;
    localparam logic [WEIGHT_W-1:0] WEIGHT_MAX = 18'd131072;
    localparam logic [SCALE_W-1:0]  XMAG_MAX   = 24'hFFFFFF;

    // apb register map, word index
    localparam int ADDR_W = 5;
    localparam int IDX_W  = 3;
    localparam logic [IDX_W-1:0] REG_MODE  = 3'd0;
    localparam logic [IDX_W-1:0] REG_SCALE = 3'd1;
    localparam logic [IDX_W-1:0] REG_DOF   = 3'd2;
    localparam logic [IDX_W-1:0] REG_TUKEY = 3'd3;
    localparam logic [IDX_W-1:0] REG_HUBER = 3'd4;

    // divider geometry
    localparam int DIV1_DW = 24;
    localparam int DIV1_QW = 24;
    localparam int DIV2_DW = 49;
    localparam int DIV2_QW = 17;
    localparam int NUM2_W  = DIV2_DW + DIV2_QW;

    typedef enum logic [1:0] {
        MODE_UNIT    = 2'd0,
        MODE_STUDENT = 2'd1,
        MODE_TUKEY   = 2'd2,
        MODE_HUBER   = 2'd3
    } mode_t;

    // how the final weight is formed
    typedef enum logic [2:0] {
        W_ZERO,
        W_ONE,
        W_MAX,
        W_QUOT,
        W_SQUARE
    } wsel_t;

    typedef struct packed {
        mode_t              mode;
        logic [SCALE_W-1:0] scale;
        logic [PAR_W-1:0]   tdist_dof;
        logic [PAR_W-1:0]   tukey_b;
        logic [PAR_W-1:0]   huber_k;
    } cfg_t;

endpackage

[rtl/core/rrw_in_if.sv]
// ----------------------------------------------------------------------------
// rrw_in_if
// residual item channel, valid/ready handshake
// ----------------------------------------------------------------------------
interface rrw_in_if;
    logic        valid;
    logic        ready;
    logic [23:0] residual;
    logic        residual_valid;

    modport source (output valid, output residual, output residual_valid, input ready);
    modport sink   (input valid, input residual, input residual_valid, output ready);
endinterface

[rtl/core/rrw_out_if.sv]
// ----------------------------------------------------------------------------
// rrw_out_if
// weight item channel, valid/ready handshake
// ----------------------------------------------------------------------------
interface rrw_out_if;
    logic        valid;
    logic        ready;
    logic [17:0] weight;

    modport source (output valid, output weight, input ready);
    modport sink   (input valid, input weight, output ready);
endinterface

[rtl/core/rrw_apb_regs.sv]
// ----------------------------------------------------------------------------
// rrw_apb_regs
// apb configuration registers: mode, scale, dof, tukey b, huber k
// ----------------------------------------------------------------------------
module rrw_apb_regs
    import rrw_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output cfg_t              cfg
);

    cfg_t             cfg_reg;
    cfg_t             cfg_next;
    logic             wr_en;
    logic [IDX_W-1:0] idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = paddr[ADDR_W-1:2];
    assign cfg    = cfg_reg;

    // write decode
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (idx)
                REG_MODE:  cfg_next.mode      = mode_t'(pwdata[1:0]);
                REG_SCALE: cfg_next.scale     = pwdata[SCALE_W-1:0];
                REG_DOF:   cfg_next.tdist_dof = pwdata[PAR_W-1:0];
                REG_TUKEY: cfg_next.tukey_b   = pwdata[PAR_W-1:0];
                REG_HUBER: cfg_next.huber_k   = pwdata[PAR_W-1:0];
                default:   cfg_next = cfg_reg;
            endcase
        end
    end

    // register storage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mode      <= MODE_STUDENT;
            cfg_reg.scale     <= 24'd65536;
            cfg_reg.tdist_dof <= 16'd1280;
            cfg_reg.tukey_b   <= 16'd1199;
            cfg_reg.huber_k   <= 16'd344;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // read mux
    always_comb
    begin
        unique case (idx)
            REG_MODE:  prdata = {30'd0, cfg_reg.mode};
            REG_SCALE: prdata = {8'd0, cfg_reg.scale};
            REG_DOF:   prdata = {16'd0, cfg_reg.tdist_dof};
            REG_TUKEY: prdata = {16'd0, cfg_reg.tukey_b};
            REG_HUBER: prdata = {16'd0, cfg_reg.huber_k};
            default:   prdata = 32'd0;
        endcase
    end

endmodule

[rtl/core/rrw_div_pipe.sv]
// ----------------------------------------------------------------------------
// rrw_div_pipe
// pipelined restoring divider, one quotient bit per stage
// numerator is {hi, lo} with hi below the divisor
// ----------------------------------------------------------------------------
module rrw_div_pipe #(
    parameter int DW = 24,
    parameter int QW = 24,
    parameter int TW = 2
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          in_vld,
    input  logic [DW-1:0] in_hi,
    input  logic [QW-1:0] in_lo,
    input  logic [DW-1:0] in_d,
    input  logic [TW-1:0] in_tag,
    output logic          out_vld,
    output logic [QW-1:0] out_q,
    output logic [TW-1:0] out_tag
);

    logic [QW-1:0] vld_reg;
    logic [DW-1:0] rem_reg [QW];
    logic [QW-1:0] q_reg   [QW];
    logic [QW-1:0] lo_reg  [QW];
    logic [DW-1:0] d_reg   [QW];
    logic [TW-1:0] tag_reg [QW];

    // per-stage next values
    logic [QW-1:0] vld_src;
    logic [DW-1:0] rem_nx  [QW];
    logic [QW-1:0] q_nx    [QW];
    logic [QW-1:0] lo_src  [QW];
    logic [DW-1:0] d_src   [QW];
    logic [TW-1:0] tag_src [QW];

    for (genvar g = 0; g < QW; g++)
    begin : g_stage
        logic [DW-1:0] src_rem;
        logic [QW-1:0] src_q;
        logic [DW:0]   trial;
        logic [DW:0]   diff;
        logic          ge;

        // stage source
        if (g == 0)
        begin : g_first
            assign vld_src[g] = in_vld;
            assign src_rem    = in_hi;
            assign lo_src[g]  = in_lo;
            assign src_q      = '0;
            assign d_src[g]   = in_d;
            assign tag_src[g] = in_tag;
        end
        else
        begin : g_later
            assign vld_src[g] = vld_reg[g-1];
            assign src_rem    = rem_reg[g-1];
            assign lo_src[g]  = lo_reg[g-1];
            assign src_q      = q_reg[g-1];
            assign d_src[g]   = d_reg[g-1];
            assign tag_src[g] = tag_reg[g-1];
        end

        // trial subtract for one quotient bit
        assign trial     = {src_rem, lo_src[g][QW-1-g]};
        assign ge        = trial >= {1'b0, d_src[g]};
        assign diff      = trial - {1'b0, d_src[g]};
        assign rem_nx[g] = ge ? diff[DW-1:0] : trial[DW-1:0];
        assign q_nx[g]   = {src_q[QW-2:0], ge};
    end

    // valid bits of all stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= vld_src;
        end
    end

    // stage data
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < QW; i++)
            begin
                rem_reg[i] <= rem_nx[i];
                q_reg[i]   <= q_nx[i];
                lo_reg[i]  <= lo_src[i];
                d_reg[i]   <= d_src[i];
                tag_reg[i] <= tag_src[i];
            end
        end
    end

    assign out_vld = vld_reg[QW-1];
    assign out_q   = q_reg[QW-1];
    assign out_tag = tag_reg[QW-1];

endmodule

[rtl/core/robust_residual_weighting_unit.sv]
// ----------------------------------------------------------------------------
// robust_residual_weighting_unit
// m-estimator weight (unit, student t, tukey, huber) per residual item
// ----------------------------------------------------------------------------
// One residual item enters per clock while the output is not stalled; the
// pipeline holds up to 48 items in flight plus the output register. Its
// depth is set by two bit-per-stage dividers: 24 stages for the scaled
// magnitude and 17 for the weight quotient, plus eight stages of setup,
// squaring and output, 49 register stages in all with the first loaded at
// the accepting edge. A stalled output freezes the whole pipeline. Write the
// configuration registers only while no item is in flight.
module robust_residual_weighting_unit
    import rrw_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    rrw_in_if.sink            in_item,
    rrw_out_if.source         out_item
);

    cfg_t cfg;
    logic adv;

    rrw_apb_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // pipeline advance: the output register is free or being emptied
    logic                out_vld_reg;
    logic [WEIGHT_W-1:0] out_weight_reg;

    assign adv           = !out_vld_reg || out_item.ready;
    assign in_item.ready = adv;

    // config-derived constants, registered off the static configuration
    logic [SCALE_W-1:0] s_eff;
    logic [XSQ_W-1:0]   tk_b2_reg;
    logic [40:0]        st_num_reg;

    assign s_eff = (cfg.scale < SCALE_MIN) ? SCALE_MIN : cfg.scale;

    always_ff @(posedge clk)
    begin
        tk_b2_reg  <= {32'(cfg.tukey_b) * 32'(cfg.tukey_b), 16'd0};
        st_num_reg <= {1'b0, cfg.tdist_dof, 24'd0} + 41'h1_0000_0000;
    end

    // stage 0: magnitude and rounded numerator
    logic [RES_W-1:0] mag;
    logic [47:0]      num1;
    logic             s0_vld_reg;
    logic             s0_rv_reg;
    logic [23:0]      s0_hi_reg;
    logic [23:0]      s0_lo_reg;

    assign mag  = in_item.residual[RES_W-1] ? (24'd0 - in_item.residual) : in_item.residual;
    assign num1 = {mag, 24'd0} + {25'd0, s_eff[SCALE_W-1:1]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            s0_vld_reg <= in_item.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s0_rv_reg <= in_item.residual_valid;
            s0_hi_reg <= num1[47:24];
            s0_lo_reg <= num1[23:0];
        end
    end

    // stage 1: saturation check of the scaled magnitude
    logic        s1_vld_reg;
    logic        s1_rv_reg;
    logic        s1_sat_reg;
    logic [23:0] s1_hi_reg;
    logic [23:0] s1_lo_reg;
    logic        sat1;

    assign sat1 = s0_hi_reg >= s_eff;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_vld_reg <= s0_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_rv_reg  <= s0_rv_reg;
            s1_sat_reg <= sat1;
            s1_hi_reg  <= sat1 ? 24'd0 : s0_hi_reg;
            s1_lo_reg  <= s0_lo_reg;
        end
    end

    // scaled magnitude divider
    logic               d1_vld;
    logic [DIV1_QW-1:0] d1_q;
    logic [1:0]         d1_tag;

    rrw_div_pipe #(
        .DW (DIV1_DW),
        .QW (DIV1_QW),
        .TW (2)
    ) u_div_mag (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (adv),
        .in_vld  (s1_vld_reg),
        .in_hi   (s1_hi_reg),
        .in_lo   (s1_lo_reg),
        .in_d    (s_eff),
        .in_tag  ({s1_rv_reg, s1_sat_reg}),
        .out_vld (d1_vld),
        .out_q   (d1_q),
        .out_tag (d1_tag)
    );

    // stage a: saturated scaled magnitude
    logic        a_vld_reg;
    logic        a_rv_reg;
    logic [23:0] a_x_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            a_vld_reg <= d1_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_rv_reg <= d1_tag[1];
            a_x_reg  <= d1_tag[0] ? XMAG_MAX : d1_q;
        end
    end

    // stage b: square of the scaled magnitude
    logic             b_vld_reg;
    logic             b_rv_reg;
    logic [23:0]      b_x_reg;
    logic [XSQ_W-1:0] b_xsq_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            b_vld_reg <= a_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            b_rv_reg  <= a_rv_reg;
            b_x_reg   <= a_x_reg;
            b_xsq_reg <= a_x_reg * a_x_reg;
        end
    end

    // stage c: numerator, divisor and weight form per influence function
    logic [DIV2_DW-1:0] den_st;
    logic [NUM2_W-1:0]  num_st;
    logic [NUM2_W-1:0]  num_tk;
    logic [NUM2_W-1:0]  num_hb;
    logic               tk_out;
    logic               hb_low;
    logic [NUM2_W-1:0]  c_num_next;
    logic [DIV2_DW-1:0] c_den_next;
    wsel_t              c_sel_next;
    logic               c_vld_reg;
    logic [NUM2_W-1:0]  c_num_reg;
    logic [DIV2_DW-1:0] c_den_reg;
    wsel_t              c_sel_reg;

    assign den_st = {9'd0, cfg.tdist_dof, 24'd0} + {1'b0, b_xsq_reg};
    assign num_st = {9'd0, st_num_reg, 16'd0} + {18'd0, den_st[DIV2_DW-1:1]};
    assign tk_out = (tk_b2_reg == '0) || (b_xsq_reg > tk_b2_reg);
    assign num_tk = {2'd0, tk_b2_reg - b_xsq_reg, 16'd0} + {19'd0, tk_b2_reg[XSQ_W-1:1]};
    assign hb_low = b_x_reg < {cfg.huber_k, 8'd0};
    assign num_hb = {26'd0, cfg.huber_k, 24'd0} + {43'd0, b_x_reg[23:1]};

    always_comb
    begin
        c_num_next = '0;
        c_den_next = '0;
        c_sel_next = W_ZERO;
        if (b_rv_reg)
        begin
            case (cfg.mode)
                MODE_UNIT:
                begin
                    c_sel_next = W_ONE;
                end
                MODE_STUDENT:
                begin
                    c_sel_next = W_QUOT;
                    c_num_next = num_st;
                    c_den_next = den_st;
                end
                MODE_TUKEY:
                begin
                    c_sel_next = tk_out ? W_ZERO : W_SQUARE;
                    c_num_next = num_tk;
                    c_den_next = {1'b0, tk_b2_reg};
                end
                MODE_HUBER:
                begin
                    c_num_next = num_hb;
                    c_den_next = {25'd0, b_x_reg};
                    if (cfg.huber_k == '0)
                    begin
                        c_sel_next = W_ZERO;
                    end
                    else if (hb_low)
                    begin
                        c_sel_next = W_ONE;
                    end
                    else
                    begin
                        c_sel_next = W_QUOT;
                    end
                end
                default:
                begin
                    c_sel_next = W_ZERO;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            c_vld_reg <= b_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            c_num_reg <= c_num_next;
            c_den_reg <= c_den_next;
            c_sel_reg <= c_sel_next;
        end
    end

    // stage d: quotient overflow check, saturates the weight
    logic [DIV2_DW-1:0] c_hi;
    logic               c_div;
    logic               sat2;
    logic               d_vld_reg;
    logic [DIV2_DW-1:0] d_hi_reg;
    logic [DIV2_QW-1:0] d_lo_reg;
    logic [DIV2_DW-1:0] d_den_reg;
    wsel_t              d_sel_reg;

    assign c_hi  = c_num_reg[NUM2_W-1:DIV2_QW];
    assign c_div = (c_sel_reg == W_QUOT) || (c_sel_reg == W_SQUARE);
    assign sat2  = c_div && (c_hi >= c_den_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            d_vld_reg <= c_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            d_hi_reg  <= (c_div && !sat2) ? c_hi : '0;
            d_lo_reg  <= c_num_reg[DIV2_QW-1:0];
            d_den_reg <= c_den_reg;
            d_sel_reg <= sat2 ? W_MAX : c_sel_reg;
        end
    end

    // weight quotient divider
    logic                d2_vld;
    logic [DIV2_QW-1:0]  d2_q;
    logic [$bits(wsel_t)-1:0] d2_tag;

    rrw_div_pipe #(
        .DW (DIV2_DW),
        .QW (DIV2_QW),
        .TW ($bits(wsel_t))
    ) u_div_wt (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (adv),
        .in_vld  (d_vld_reg),
        .in_hi   (d_hi_reg),
        .in_lo   (d_lo_reg),
        .in_d    (d_den_reg),
        .in_tag  (d_sel_reg),
        .out_vld (d2_vld),
        .out_q   (d2_q),
        .out_tag (d2_tag)
    );

    // stage e: tukey square of the quotient
    logic                 e_vld_reg;
    logic [DIV2_QW-1:0]   e_q_reg;
    logic [2*DIV2_QW-1:0] e_sq_reg;
    wsel_t                e_sel_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            e_vld_reg <= d2_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            e_q_reg   <= d2_q;
            e_sq_reg  <= d2_q * d2_q;
            e_sel_reg <= wsel_t'(d2_tag);
        end
    end

    // output register: final weight selection
    logic [2*DIV2_QW-1:0] sq_rnd;
    logic [WEIGHT_W-1:0]  out_weight_next;

    assign sq_rnd = e_sq_reg + 34'd32768;

    always_comb
    begin
        case (e_sel_reg)
            W_ONE:    out_weight_next = WEIGHT_ONE;
            W_MAX:    out_weight_next = WEIGHT_MAX;
            W_QUOT:   out_weight_next = {1'b0, e_q_reg};
            W_SQUARE: out_weight_next = sq_rnd[33:16];
            default:  out_weight_next = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_vld_reg <= e_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_weight_reg <= out_weight_next;
        end
    end

    assign out_item.valid  = out_vld_reg;
    assign out_item.weight = out_weight_reg;

endmodule

[rtl/core/rrw_checker.sv]
// ----------------------------------------------------------------------------
// rrw_checker
// port-level checks on the robust residual weighting unit
// ----------------------------------------------------------------------------
`include "robust_residual_weighting_unit_macros.svh"

module rrw_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [17:0] weight
);

    // a stalled weight item holds
    `RRW_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(weight))
    // weight never exceeds two
    `RRW_ASSERT_IMPL(a_weight_range, clk, rst_n, out_valid, weight <= 18'd131072)
    // an empty output register always lets items in
    `RRW_ASSERT_IMPL(a_ready_free, clk, rst_n, !out_valid, in_ready)
    // a stalled output freezes the pipeline input
    `RRW_ASSERT_IMPL(a_ready_stall, clk, rst_n, out_valid && !out_ready, !in_ready)

endmodule

bind robust_residual_weighting_unit rrw_checker u_rrw_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_item.valid),
    .in_ready  (in_item.ready),
    .out_valid (out_item.valid),
    .out_ready (out_item.ready),
    .weight    (out_item.weight)
);
